/* src/mrh_pkg.sv */
package mrh_pkg;

  // Geometry of the image and the column store
  localparam int MaxCols = 1024;
  localparam int MaxRows = 1024;
  localparam int ColW    = $clog2(MaxCols);
  localparam int CntW    = $clog2(MaxCols + 1);
  localparam int HgtW    = $clog2(MaxRows + 1);
  localparam int ProdW   = 2 * HgtW;
  localparam int AreaW   = 21;

  localparam logic [CntW-1:0]  MaxColsCnt = CntW'(MaxCols);
  localparam logic [HgtW-1:0]  MaxRowsHgt = HgtW'(MaxRows);
  localparam logic [ProdW-1:0] AreaMax    = ProdW'((64'd1 << AreaW) - 64'd1);

  // Reset value of the row width register
  localparam logic [CntW-1:0] RowWidthRst = CntW'(1024);

  // One bar of the monotonic stack
  typedef struct packed {
    logic [ColW-1:0] col;
    logic [HgtW-1:0] hgt;
  } bar_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_CHK,
    ST_POP,
    ST_PUSH,
    ST_FIN
  } mrh_state_e;

endpackage

/* src/maximal_rectangle_histogram_stack.sv */
// Largest all-ones rectangle over a streamed binary image, one cell per transfer.
// A new cell is taken only in the idle state: in_stall_o is high while the column height is
// updated and bars are popped and pushed, and while the stack is flushed at each row end.
// The area is registered after the frame-end transfer once the stack is flushed; it waits
// while an earlier area is held. Reset: stack, column count, best area and fill count clear,
// row width returns to 1024; no clearing pass is needed.
module maximal_rectangle_histogram_stack (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cell_req_i,
  input  logic                        frame_end_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mrh_pkg::AreaW-1:0]   rect_area_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mrh_pkg::CntW-1:0]    cfg_data_i
);
  import mrh_pkg::*;

  mrh_state_e state_q, state_d;

  logic [CntW-1:0]  row_width_q;
  logic [CntW-1:0]  eff_width;
  logic [ColW-1:0]  col_idx_q, col_idx_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]  depth_q, depth_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [HgtW-1:0]  cur_hgt_q, cur_hgt_d;
  bar_t             top_q, top_d;
  logic             flush_q, flush_d;
  logic             cell_q, fe_q;
  logic             out_valid_q, out_valid_d;
  logic [AreaW-1:0] out_area_q;

  // Memory ports
  logic [HgtW-1:0] hgt_mem [MaxCols];
  logic [HgtW-1:0] hgt_rdata_q;
  logic            hgt_re, hgt_we;
  logic [HgtW-1:0] hgt_wdata;

  bar_t            bar_mem [MaxCols];
  bar_t            bar_rdata_q;
  logic            bar_re, bar_we;
  logic [ColW-1:0] bar_raddr;

  // Area unit control
  logic             offer_valid;
  logic [HgtW-1:0]  offer_wid;
  logic             best_clear;
  logic [AreaW-1:0] best_area;

  logic             accept;
  logic             out_busy;
  logic             pop_go;
  logic             row_end;
  logic [HgtW-1:0]  old_hgt;
  logic [HgtW-1:0]  new_hgt;
  logic [CntW-1:0]  col_ext;

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_busy = out_valid_q && out_stall_i;
  assign col_ext  = {1'b0, col_idx_q};
  assign pop_go   = (depth_q != '0) && (top_q.hgt >= cur_hgt_q);

  // Clamp the row width to 1..MaxCols
  always_comb begin
    eff_width = row_width_q;
    if (row_width_q == '0) begin
      eff_width = CntW'(1);
    end else if (row_width_q > MaxColsCnt) begin
      eff_width = MaxColsCnt;
    end
  end

  assign row_end = ((col_ext + CntW'(1)) >= eff_width) || fe_q;

  // Update the column height; entries beyond the fill count read as zero
  always_comb begin
    old_hgt = (col_ext < fill_q) ? hgt_rdata_q : '0;
    if (!cell_q) begin
      new_hgt = '0;
    end else if (old_hgt < MaxRowsHgt) begin
      new_hgt = old_hgt + HgtW'(1);
    end else begin
      new_hgt = old_hgt;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: state_d = ST_CHK;
      ST_CHK: begin
        if (pop_go) begin
          state_d = ST_POP;
        end else if (flush_q) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_POP:  state_d = ST_CHK;
      ST_PUSH: state_d = row_end ? ST_CHK : ST_IDLE;
      ST_FIN: begin
        if (!(fe_q && out_busy)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    col_idx_d   = col_idx_q;
    fill_d      = fill_q;
    depth_d     = depth_q;
    pos_d       = pos_q;
    cur_hgt_d   = cur_hgt_q;
    top_d       = top_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q && out_stall_i;
    hgt_re      = 1'b0;
    hgt_we      = 1'b0;
    hgt_wdata   = new_hgt;
    bar_re      = 1'b0;
    bar_we      = 1'b0;
    bar_raddr   = ColW'(depth_q - CntW'(2));
    offer_valid = 1'b0;
    offer_wid   = pos_q;
    best_clear  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        hgt_re = accept;
      end
      ST_UPD: begin
        // Write back the height and start settling at this column
        hgt_we    = 1'b1;
        cur_hgt_d = new_hgt;
        pos_d     = col_ext;
        flush_d   = 1'b0;
        if (col_ext >= fill_q) begin
          fill_d = col_ext + CntW'(1);
        end
      end
      ST_CHK: begin
        // Fetch the bar below the top
        bar_re = pop_go;
      end
      ST_POP: begin
        // Drop the top bar and offer its rectangle
        offer_valid = 1'b1;
        if (depth_q > CntW'(1)) begin
          offer_wid = pos_q - {1'b0, bar_rdata_q.col} - CntW'(1);
        end
        depth_d = depth_q - CntW'(1);
        top_d   = bar_rdata_q;
      end
      ST_PUSH: begin
        if (depth_q < MaxColsCnt) begin
          bar_we  = 1'b1;
          top_d   = '{col: col_idx_q, hgt: cur_hgt_q};
          depth_d = depth_q + CntW'(1);
        end
        if (row_end) begin
          pos_d     = col_ext + CntW'(1);
          cur_hgt_d = '0;
          flush_d   = 1'b1;
        end else begin
          col_idx_d = col_idx_q + ColW'(1);
        end
      end
      ST_FIN: begin
        depth_d   = '0;
        col_idx_d = '0;
        flush_d   = 1'b0;
        if (fe_q && !out_busy) begin
          out_valid_d = 1'b1;
          best_clear  = 1'b1;
          fill_d      = '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_width_q <= RowWidthRst;
      col_idx_q   <= '0;
      fill_q      <= '0;
      depth_q     <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_idx_q   <= col_idx_d;
      fill_q      <= fill_d;
      depth_q     <= depth_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        row_width_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    cur_hgt_q <= cur_hgt_d;
    top_q     <= top_d;
    if (accept) begin
      cell_q <= cell_req_i;
      fe_q   <= frame_end_i;
    end
    if (state_q == ST_FIN && fe_q && !out_busy) begin
      out_area_q <= best_area;
    end
  end

  // Column height memory
  always_ff @(posedge clk_i) begin
    if (hgt_we) begin
      hgt_mem[col_idx_q] <= hgt_wdata;
    end
    if (hgt_re) begin
      hgt_rdata_q <= hgt_mem[col_idx_q];
    end
  end

  // Bar stack memory
  always_ff @(posedge clk_i) begin
    if (bar_we) begin
      bar_mem[depth_q[ColW-1:0]] <= '{col: col_idx_q, hgt: cur_hgt_q};
    end
    if (bar_re) begin
      bar_rdata_q <= bar_mem[bar_raddr];
    end
  end

  mrh_area_tracker u_area (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .offer_valid_i (offer_valid),
    .bar_hgt_i     (top_q.hgt),
    .bar_wid_i     (offer_wid),
    .clear_i       (best_clear),
    .best_o        (best_area)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign rect_area_o = out_area_q;
  assign cfg_ready_o = 1'b1;

endmodule

/* src/mrh_area_tracker.sv */
module mrh_area_tracker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       offer_valid_i,
  input  logic [mrh_pkg::HgtW-1:0]   bar_hgt_i,
  input  logic [mrh_pkg::HgtW-1:0]   bar_wid_i,
  input  logic                       clear_i,
  output logic [mrh_pkg::AreaW-1:0]  best_o
);
  import mrh_pkg::*;

  logic [ProdW-1:0] prod_q, prod_d;
  logic             prod_vld_q;
  logic [AreaW-1:0] best_q, best_d;
  logic [AreaW-1:0] sat_area;

  // Multiply the offered bar
  assign prod_d = ProdW'(bar_hgt_i) * ProdW'(bar_wid_i);

  // Saturate and keep the running maximum
  always_comb begin
    sat_area = (prod_q > AreaMax) ? AreaMax[AreaW-1:0] : prod_q[AreaW-1:0];
    best_d   = best_q;
    if (prod_vld_q && (sat_area > best_q)) begin
      best_d = sat_area;
    end
    if (clear_i) begin
      best_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      best_q     <= '0;
    end else begin
      prod_vld_q <= offer_valid_i;
      best_q     <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (offer_valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign best_o = best_q;

endmodule

/* sim/mrh_area_checker.sv */
`timescale 1ns / 100ps

module mrh_area_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      cell_req_i,
  input  logic                      frame_end_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [mrh_pkg::AreaW-1:0] rect_area_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [mrh_pkg::CntW-1:0]  cfg_data_i,
  output int unsigned               err_cnt_o,
  output int unsigned               pend_cnt_o,
  output int unsigned               area_cnt_o
);
  import mrh_pkg::*;

  localparam longint unsigned AreaLimit = (64'd1 << AreaW) - 64'd1;

  // Shadow of the block's frame state
  logic [HgtW-1:0]  col_hgt [MaxCols];
  bar_t             bars [MaxCols];
  int unsigned      bar_cnt;
  int unsigned      col_pos;
  logic [AreaW-1:0] best_area;
  logic [CntW-1:0]  row_width;
  logic [AreaW-1:0] area_q [$];
  logic [AreaW-1:0] exp_area;

  // Clear heights, stack, column position and best area
  task automatic clear_frame();
    for (int unsigned i = 0; i < MaxCols; i++) col_hgt[i] = '0;
    bar_cnt   = 0;
    col_pos   = 0;
    best_area = '0;
  endtask

  // Keep the larger of the running best and this rectangle, saturated
  task automatic offer_area(input longint unsigned hgt, input longint unsigned wid);
    longint unsigned prod;
    prod = hgt * wid;
    if (prod > AreaLimit) prod = AreaLimit;
    if (prod > best_area) best_area = AreaW'(prod);
  endtask

  // Pop every bar at least as tall as hgt, scoring the rectangle each bounds
  task automatic pop_bars(input int unsigned pos, input int unsigned hgt);
    int unsigned wid;
    while (bar_cnt > 0 && bars[bar_cnt-1].hgt >= hgt) begin
      bar_cnt--;
      wid = (bar_cnt != 0) ? pos - bars[bar_cnt-1].col - 1 : pos;
      offer_area(bars[bar_cnt].hgt, wid);
    end
  endtask

  // Advance the histogram by one cell; queue the area at the end of a frame
  task automatic step_cell(input logic cell_val, input logic last);
    int unsigned wid;
    int unsigned col;
    int unsigned hgt;
    wid = row_width;
    if (wid < 1) wid = 1;
    if (wid > MaxCols) wid = MaxCols;
    col = (col_pos >= MaxCols) ? MaxCols - 1 : col_pos;

    hgt = col_hgt[col];
    if (cell_val) begin
      if (hgt < MaxRows) hgt++;
    end else begin
      hgt = 0;
    end
    col_hgt[col] = HgtW'(hgt);

    pop_bars(col, hgt);
    if (bar_cnt < MaxCols) begin
      bars[bar_cnt].col = ColW'(col);
      bars[bar_cnt].hgt = HgtW'(hgt);
      bar_cnt++;
    end

    // Flush the stack at a row end, including one cut short by the frame end
    if (col + 1 >= wid || last) begin
      pop_bars(col + 1, 0);
      bar_cnt = 0;
      col_pos = 0;
    end else begin
      col_pos = col + 1;
    end

    if (last) begin
      area_q.push_back(best_area);
      clear_frame();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      row_width = RowWidthRst;
      area_q.delete();
      err_cnt_o  <= 0;
      pend_cnt_o <= 0;
      area_cnt_o <= 0;
    end else begin
      // Compare a result transfer with the oldest expected area
      if (out_valid_i && !out_stall_i) begin
        if (area_q.size() == 0) begin
          $error("rect_area: expected none, actual %0d", rect_area_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_area = area_q.pop_front();
          if (rect_area_i !== exp_area) begin
            $error("rect_area: expected %0d, actual %0d", exp_area, rect_area_i);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
        area_cnt_o <= area_cnt_o + 1;
      end

      if (cfg_valid_i && cfg_ready_i) row_width = cfg_data_i;

      if (in_valid_i && !in_stall_i) step_cell(cell_req_i, frame_end_i);

      pend_cnt_o <= area_q.size();
    end
  end

endmodule

/* sim/maximal_rectangle_histogram_stack_tb.sv */
`timescale 1ns / 100ps

module maximal_rectangle_histogram_stack_tb;
  import mrh_pkg::*;

  // Worst flush of a full stack plus the output pipeline
  localparam int unsigned SettleCycles = 2 * MaxCols + 64;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned RandCells    = 450;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic             cell_req  = 1'b0;
  logic             frame_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [AreaW-1:0] rect_area;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CntW-1:0]  cfg_data  = '0;

  int unsigned err_cnt;
  int unsigned pend_cnt;
  int unsigned area_cnt;

  bit          tx_quiet     = 1'b0;
  bit          rx_quiet     = 1'b0;
  bit          rx_hold_req  = 1'b0;
  int unsigned eff_width    = MaxCols;
  int unsigned cells_sent   = 0;
  int unsigned frames_sent  = 0;
  int unsigned width_writes = 0;

  maximal_rectangle_histogram_stack u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cell_req_i  (cell_req),
    .frame_end_i (frame_end),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .rect_area_o (rect_area),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  mrh_area_checker u_area_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .cell_req_i  (cell_req),
    .frame_end_i (frame_end),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .rect_area_i (rect_area),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .err_cnt_o   (err_cnt),
    .pend_cnt_o  (pend_cnt),
    .area_cnt_o  (area_cnt)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Stall the result channel at random, or hold it off for a long stretch on request
  initial begin : rx_stall_gen
    int unsigned span;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        span = pick_gap(rx_quiet);
        if (span != 0) begin
          out_stall <= 1'b1;
          repeat (span) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Offer one cell after a random gap and hold it until the transfer
  task automatic send_cell(input logic cell_val, input logic last);
    int unsigned gap;
    gap = pick_gap(tx_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cell_req  <= cell_val;
    frame_end <= last;
    do @(posedge clk); while (in_stall);
    cells_sent++;
    if (last) frames_sent++;
  endtask

  // Drop valid and wait until every expected area has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pend_cnt != 0);
  endtask

  // Write the row width once the block has gone quiet
  task automatic write_width(input logic [CntW-1:0] wid);
    wait_drain();
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= wid;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eff_width = (wid == 0) ? 1 : (wid > MaxCols) ? MaxCols : wid;
    width_writes++;
  endtask

  // Send a frame of full rows, or with the frame end early in the last row
  task automatic send_frame(input int unsigned rows, input int unsigned density,
                            input bit cut);
    int unsigned stop_col;
    logic        last;
    stop_col = eff_width - 1;
    if (cut) stop_col = $urandom_range(0, (eff_width > 40) ? 40 : eff_width - 1);
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < eff_width; c++) begin
        last = (r == rows - 1) && (c == stop_col);
        send_cell($urandom_range(0, 99) < density, last);
        if (last) break;
      end
    end
  endtask

  // Random cells with frame ends anywhere; always close the last frame
  task automatic send_noise(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_cell(1'($urandom_range(0, 1)),
                (i == count - 1) || ($urandom_range(0, 24) == 0));
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned r;
    int unsigned w;
    int unsigned rows;
    int unsigned density;
    int unsigned rand_stop;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset width: a frame ending partway through its first row, then an empty cell
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b1);
    send_cell(1'b0, 1'b1);

    // Zero width acts as a single column
    write_width('0);
    repeat (3) send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);

    // Narrow the width while a row is open past the new edge
    write_width(CntW'(8));
    repeat (5) send_cell(1'b1, 1'b0);
    write_width(CntW'(3));
    repeat (3) send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);

    // Width just above the store clamps to the full store
    write_width(CntW'(MaxCols + 1));
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);

    // Hold the results off while single-cell frames keep coming
    write_width(CntW'(1));
    rx_hold_req = 1'b1;
    while (rx_hold_req) @(posedge clk);
    tx_quiet = 1'b1;
    repeat (24) send_cell(1'($urandom_range(0, 1)), 1'b1);
    tx_quiet = 1'b0;
    wait_drain();

    // Random frames, mostly well formed, over changing widths
    phase     = 0;
    rand_stop = cells_sent + RandCells;
    while (cells_sent < rand_stop || area_cnt < 40) begin
      if (phase % 3 == 0) begin
        r = $urandom_range(0, 99);
        if (r < 70) w = $urandom_range(1, 12);
        else if (r < 90) w = $urandom_range(13, 48);
        else if (r < 95) w = 0;
        else w = $urandom_range(0, 1) ? MaxCols : $urandom_range(MaxCols + 1, 2047);
        write_width(CntW'(w));
        tx_quiet = ($urandom_range(0, 4) == 0);
        rx_quiet = ($urandom_range(0, 4) == 0);
      end
      phase++;
      case ($urandom_range(0, 3))
        0: density = 20;
        1: density = 50;
        2: density = 85;
        default: density = 100;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        send_noise($urandom_range(5, 40));
      end else if (eff_width > 64) begin
        send_frame(1, density, 1'b1);
      end else begin
        rows = $urandom_range(1, (eff_width <= 4) ? 24 : 8);
        send_frame(rows, density, $urandom_range(0, 99) < 15);
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    wait_drain();
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d cells in %0d frames across %0d row-width writes; %0d areas checked.",
             cells_sent, frames_sent, width_writes, area_cnt);
    $display("Covered clamped widths, a mid-row width change, early frame ends, %s",
             "random densities and a long result hold with input backpressure.");
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
src/mrh_pkg.sv
src/mrh_area_tracker.sv
src/maximal_rectangle_histogram_stack.sv
sim/mrh_area_checker.sv
sim/maximal_rectangle_histogram_stack_tb.sv
